// ===== sv/ordered_list_engine_unit_defines.svh =====
// Assertion macros for the ordered list engine.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

// Implication in the same cycle, checked on every rising edge out of reset.
`define OLIST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define OLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/olist_pkg.sv =====
// Shared types and constants of the ordered list engine.
// No dependencies; used by the cells and the top level.
package olist_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 13;

  typedef enum logic [2:0] {
    MODE_PUSH      = 3'd0,
    MODE_POP       = 3'd1,
    MODE_READ      = 3'd2,
    MODE_WRITE     = 3'd3,
    MODE_INSERT    = 3'd4,
    MODE_DELETE_AT = 3'd5,
    MODE_DELETE_V  = 3'd6,
    MODE_NOP       = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_SET        = 3'd1,
    CELL_INSERT     = 3'd2,
    CELL_DELETE     = 3'd3,
    CELL_REMOVE_HIT = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/olist_req_if.sv =====
// Request channel of the ordered list engine: valid/ready plus the request fields.
// No dependencies.
interface olist_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// ===== sv/olist_rsp_if.sv =====
// Response channel of the ordered list engine: valid/ready plus the result fields.
// No dependencies.
interface olist_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [8:0]         count;
  logic [2:0]         status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface

// ===== sv/olist_cell.sv =====
// One storage cell of the list chain: holds one word and takes its neighbors' words.
// Depends on olist_pkg.
module olist_cell #(
  parameter int unsigned K = 0
) (
  input  logic                              clk_i,
  input  olist_pkg::cell_cmd_t              cmd_i,
  input  logic signed [olist_pkg::DATA_W-1:0] left_i,
  input  logic signed [olist_pkg::DATA_W-1:0] right_i,
  input  logic                              hit_i,
  output logic signed [olist_pkg::DATA_W-1:0] word_o,
  output logic signed [olist_pkg::DATA_W-1:0] rd_o,
  output logic                              match_o
);
  import olist_pkg::*;

  localparam logic [IDX_W-1:0] Index = IDX_W'(K);

  logic signed [DATA_W-1:0] word_q, word_d;
  logic                     match_q;

  always_comb begin
    word_d = word_q;
    unique case (cmd_i.op)
      CELL_HOLD: begin
        word_d = word_q;
      end
      CELL_SET: begin
        if (Index == cmd_i.idx) word_d = cmd_i.value;
      end
      CELL_INSERT: begin
        if (Index == cmd_i.idx) begin
          word_d = cmd_i.value;
        end else if (Index > cmd_i.idx) begin
          word_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (Index >= cmd_i.idx) word_d = right_i;
      end
      CELL_REMOVE_HIT: begin
        if (hit_i) word_d = right_i;
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    match_q <= (word_q == cmd_i.value) && (Index < cmd_i.count);
  end

  assign word_o  = word_q;
  assign match_o = match_q;
  assign rd_o    = (Index == cmd_i.rd_idx) ? word_q : '0;

endmodule

// ===== sv/olist_prefix.sv =====
// Inclusive prefix OR over the cell match flags, built as a log-depth network.
// No dependencies.
module olist_prefix #(
  parameter int unsigned Width = 256
) (
  input  logic [Width-1:0] in_i,
  output logic [Width-1:0] out_o
);
  localparam int unsigned Levels = (Width > 1) ? $clog2(Width) : 1;

  logic [Width-1:0] lvl [Levels+1];

  assign lvl[0] = in_i;

  for (genvar s = 0; s < Levels; s++) begin : g_level
    for (genvar i = 0; i < Width; i++) begin : g_bit
      if (i >= (1 << s)) begin : g_or
        assign lvl[s+1][i] = lvl[s][i] | lvl[s][i-(1<<s)];
      end else begin : g_pass
        assign lvl[s+1][i] = lvl[s][i];
      end
    end
  end

  assign out_o = lvl[Levels];

endmodule

// ===== sv/ordered_list_engine_unit.sv =====
// Top level of the ordered list engine: control, cell chain, read tree, result register.
// Depends on olist_pkg, olist_req_if, olist_rsp_if, olist_cell, olist_prefix and the defines.
//
//   channel | direction | payload                       | transfer when
//   req_i   | in        | mode, position, value         | req_i.valid && req_i.ready
//   rsp_o   | out       | read_value, count, status     | rsp_o.valid && rsp_o.ready
//
// One request is worked on at a time; the next is taken once the result is registered.
// Push, write, insert, delete at, no-op and a refused read or pop go from exec to done.
// Good read/pop adds gather (registered read tree), delete value search (match row).
// Reset clears the count and the control; the list words need no reset.
// A stalled response holds in its register while the next request is already worked on.
module ordered_list_engine_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olist_req_if.sink   req_i,
  olist_rsp_if.source rsp_o
);
  import olist_pkg::*;

  `include "ordered_list_engine_unit_defines.svh"

  localparam int unsigned CntW      = $clog2(CAPACITY + 1);
  localparam int unsigned GroupSize = 64;
  localparam int unsigned NumGroups = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam logic [IDX_W-1:0] CapIdx = IDX_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_GATHER = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  mode_e                    mode_q;
  logic [7:0]               pos_q;
  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] rd_q;
  status_e                  st_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_rd_q;
  logic [8:0]               out_cnt_q;
  status_e                  out_st_q;

  cell_cmd_t                cmd;
  status_e                  st_exec;
  logic [IDX_W-1:0]         count_ext, pos_ext;
  logic                     accept, load_out, hit;

  logic signed [DATA_W-1:0] cell_word [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [CAPACITY-1:0]      match, prefix;
  logic signed [DATA_W-1:0] grp_d [NumGroups];
  logic signed [DATA_W-1:0] grp_q [NumGroups];
  logic signed [DATA_W-1:0] tree_rd;

  assign count_ext = IDX_W'(count_q);
  assign pos_ext   = IDX_W'(pos_q);
  assign accept    = req_i.valid && req_i.ready;
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);
  assign hit       = prefix[CAPACITY-1];

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    st_exec     = ST_OK;
    cmd.op      = CELL_HOLD;
    cmd.idx     = pos_ext;
    cmd.rd_idx  = (mode_q == MODE_POP) ? (count_ext - 1'b1) : pos_ext;
    cmd.count   = count_ext;
    cmd.value   = value_q;
    count_d     = count_q;
    unique case (mode_q)
      MODE_PUSH: begin
        if (count_ext >= CapIdx) begin
          st_exec = ST_FULL;
        end else begin
          cmd.op  = CELL_SET;
          cmd.idx = count_ext;
          count_d = count_q + 1'b1;
        end
      end
      MODE_POP: begin
        if (count_q == '0) begin
          st_exec = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      MODE_READ: begin
        if (pos_ext >= count_ext) st_exec = ST_RANGE;
      end
      MODE_WRITE: begin
        if (pos_ext >= count_ext) begin
          st_exec = ST_RANGE;
        end else begin
          cmd.op = CELL_SET;
        end
      end
      MODE_INSERT: begin
        if (count_ext >= CapIdx) begin
          st_exec = ST_FULL;
        end else if (pos_ext > count_ext) begin
          st_exec = ST_RANGE;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      MODE_DELETE_AT: begin
        if (pos_ext >= count_ext) begin
          st_exec = ST_RANGE;
        end else begin
          cmd.op  = CELL_DELETE;
          count_d = count_q - 1'b1;
        end
      end
      MODE_DELETE_V: begin
        st_exec = ST_OK;
      end
      MODE_NOP: begin
        st_exec = ST_OK;
      end
      default: begin
        st_exec = ST_OK;
      end
    endcase

    if (state_q == S_SEARCH) begin
      cmd.op  = hit ? CELL_REMOVE_HIT : CELL_HOLD;
      count_d = hit ? (count_q - 1'b1) : count_q;
    end else if (state_q != S_EXEC) begin
      cmd.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = value_q;
    end else begin : g_mid_l
      assign left = cell_word[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = cell_word[k];
    end else begin : g_mid_r
      assign right = cell_word[k+1];
    end
    olist_cell #(.K(k)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .hit_i   (prefix[k]),
      .word_o  (cell_word[k]),
      .rd_o    (cell_rd[k]),
      .match_o (match[k])
    );
  end

  olist_prefix #(.Width(CAPACITY)) u_prefix (
    .in_i  (match),
    .out_o (prefix)
  );

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if (g * GroupSize + j < CAPACITY) grp_d[g] = grp_d[g] | cell_rd[g * GroupSize + j];
      end
    end
  end

  always_comb begin
    tree_rd = '0;
    for (int g = 0; g < NumGroups; g++) begin
      tree_rd = tree_rd | grp_q[g];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (mode_q == MODE_DELETE_V) begin
          state_d = S_SEARCH;
        end else if ((mode_q == MODE_POP || mode_q == MODE_READ) && st_exec == ST_OK) begin
          state_d = S_GATHER;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SEARCH: begin
        state_d = S_DONE;
      end
      S_GATHER: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_e'(req_i.mode);
      pos_q   <= req_i.position;
      value_q <= req_i.value;
    end
    for (int g = 0; g < NumGroups; g++) begin
      grp_q[g] <= grp_d[g];
    end
    if (state_q == S_EXEC) begin
      rd_q <= '0;
      st_q <= st_exec;
    end
    if (state_q == S_GATHER) rd_q <= tree_rd;
    if (state_q == S_SEARCH) st_q <= hit ? ST_OK : ST_MISSING;
    if (load_out) begin
      out_rd_q  <= rd_q;
      out_cnt_q <= 9'(count_q);
      out_st_q  <= st_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_rd_q;
  assign rsp_o.count      = out_cnt_q;
  assign rsp_o.status     = out_st_q;

  `OLIST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `OLIST_ASSERT_NEXT(a_count_step, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1), "count moved by more than one")
  `OLIST_ASSERT_NOW(a_fail_zero, rsp_o.valid && (rsp_o.status != ST_OK), rsp_o.read_value == '0, "failed request returned data")
  `OLIST_ASSERT_NEXT(a_accept_exec, accept, state_q == S_EXEC, "accepted request not executed")

endmodule
